// ----- hw/rtl/weighted_next_hop_select_defines.svh -----
// assertion macros for the weighted next hop selector
`ifndef WEIGHTED_NEXT_HOP_SELECT_DEFINES_SVH
`define WEIGHTED_NEXT_HOP_SELECT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define WNHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define WNHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wnhs_pkg.sv -----
// shared constants and types of the weighted next hop selector
`default_nettype none

package wnhs_pkg;

    localparam int NODES_DEFAULT       = 16;
    localparam int WEIGHT_BITS_DEFAULT = 16;
    localparam int RAND_BITS_DEFAULT   = 16;

    // fixed widths of the word fields
    localparam int NODE_FIELD_BITS   = 4;
    localparam int WEIGHT_FIELD_BITS = 16;
    localparam int RAND_FIELD_BITS   = 16;

    // node numbers that a 4-bit field can name
    localparam int NODE_SPAN = 1 << NODE_FIELD_BITS;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // nodes that can ever be written or queried
    function automatic int active_nodes(input int nodes);
        return (nodes < NODE_SPAN) ? nodes : NODE_SPAN;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wnhs_table.sv -----
// weight table memory with per-entry valid bits and registered read
`default_nettype none

module wnhs_table #(
    parameter int DEPTH       = wnhs_pkg::NODE_SPAN * wnhs_pkg::NODE_SPAN,
    parameter int WEIGHT_BITS = wnhs_pkg::WEIGHT_BITS_DEFAULT,
    localparam int ADDR_W     = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_wr_en,
    input  wire logic [ADDR_W-1:0]      i_wr_addr,
    input  wire logic [WEIGHT_BITS-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]      i_rd_addr,
    output logic      [WEIGHT_BITS-1:0] o_rd_data
);

    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]       r_valid;
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic                   r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_next_hop_select.sv -----
// top level of the weighted next hop selector (roulette wheel over a weight table)
//
// input channel: i_in_valid / o_in_stall with fields i_cmd, i_current_node, i_dest_node,
// i_link_weight and i_rand_fraction. a write word (cmd 0) stores one weight in the cycle
// it is accepted and gives no result; the next word can follow straight away.
// a query word (cmd 1) gives one result word on o_out_valid / i_out_stall carrying
// o_next_hop and o_direct_hit.
// a direct hit (nonzero weight for the destination) holds the input stalled through the
// check and done states, and the result is loaded from the done state. a query from a
// node beyond the table gives node 0 the same way. otherwise the row is read twice through
// the single table read port, one entry a cycle: a pass that sums weight times fraction
// through the multiply-accumulate, then a pass of running sums compared with the
// threshold, which stops at the chosen neighbour; the input stays stalled throughout.
// only the first 16 nodes are addressable by the 4-bit node fields.
// the result sits in an output register; while the receiver stalls it holds, and a
// finished query waits until that register is free, the input staying stalled.
// reset clears the table valid bits (table reads as all zero) and empties the output
// register; there is no clearing pass.
`default_nettype none

`include "weighted_next_hop_select_defines.svh"

module weighted_next_hop_select #(
    parameter int NODES       = wnhs_pkg::NODES_DEFAULT,
    parameter int WEIGHT_BITS = wnhs_pkg::WEIGHT_BITS_DEFAULT,
    parameter int RAND_BITS   = wnhs_pkg::RAND_BITS_DEFAULT
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_stall,
    input  wire logic                                      i_cmd,
    input  wire logic [wnhs_pkg::NODE_FIELD_BITS-1:0]      i_current_node,
    input  wire logic [wnhs_pkg::NODE_FIELD_BITS-1:0]      i_dest_node,
    input  wire logic [wnhs_pkg::WEIGHT_FIELD_BITS-1:0]    i_link_weight,
    input  wire logic [wnhs_pkg::RAND_FIELD_BITS-1:0]      i_rand_fraction,
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_stall,
    output logic      [wnhs_pkg::NODE_FIELD_BITS-1:0]      o_next_hop,
    output logic                                           o_direct_hit
);

    localparam int NODE_W = wnhs_pkg::NODE_FIELD_BITS;
    // nodes reachable through the node fields
    localparam int ACT    = wnhs_pkg::active_nodes(NODES);
    localparam int IDX_W  = $clog2(ACT);
    localparam int CNT_W  = $clog2(ACT + 1);
    localparam int DEPTH  = ACT * ACT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = WEIGHT_BITS + $clog2(ACT);
    localparam int PROD_W = WEIGHT_BITS + RAND_BITS;
    localparam int ACC_W  = SUM_W + RAND_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_dst, n_dst;
    logic               r_row_ok, n_row_ok;
    logic               r_dst_ok, n_dst_ok;
    logic [RAND_BITS-1:0] r_rand, n_rand;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [IDX_W-1:0]   r_rcol, n_rcol;
    logic               r_rv, n_rv;
    logic               r_pv, n_pv;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [SUM_W-1:0]   r_run, n_run;
    logic [IDX_W-1:0]   r_hop, n_hop;
    logic               r_hit, n_hit;
    logic               r_out_valid, n_out_valid;
    logic [NODE_W-1:0]  r_out_hop, n_out_hop;
    logic               r_out_hit, n_out_hit;

    logic                   w_in_accept;
    logic                   w_in_row_ok;
    logic                   w_in_dst_ok;
    logic [IDX_W-1:0]       w_in_row;
    logic [IDX_W-1:0]       w_in_dst;
    logic [ADDR_W-1:0]      w_in_addr;
    logic                   w_wr_en;
    logic                   w_issue;
    logic [IDX_W-1:0]       w_scan_col;
    logic [ADDR_W-1:0]      w_scan_addr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic [WEIGHT_BITS-1:0] w_rd_data;
    logic [SUM_W-1:0]       w_thr;
    logic [SUM_W-1:0]       w_run_next;
    logic                   w_load;

    // input side
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // nodes beyond the table are ignored on writes and read as zero on queries
    assign w_in_row_ok = (32'(i_current_node) < ACT);
    assign w_in_dst_ok = (32'(i_dest_node) < ACT);
    assign w_in_row    = w_in_row_ok ? i_current_node[IDX_W-1:0] : '0;
    assign w_in_dst    = w_in_dst_ok ? i_dest_node[IDX_W-1:0] : '0;
    assign w_in_addr   = ADDR_W'(w_in_row) * ADDR_W'(ACT) + ADDR_W'(w_in_dst);
    assign w_wr_en     = w_in_accept && (i_cmd == wnhs_pkg::CMD_WRITE)
                         && w_in_row_ok && w_in_dst_ok;

    // one row entry read per cycle during the two passes
    assign w_issue     = ((r_state == ST_SUM) || (r_state == ST_SCAN))
                         && (r_col < CNT_W'(ACT));
    assign w_scan_col  = w_issue ? r_col[IDX_W-1:0] : '0;
    assign w_scan_addr = ADDR_W'(r_cur) * ADDR_W'(ACT) + ADDR_W'(w_scan_col);
    // in idle the entry of the incoming word is read, ready for the direct check
    assign w_rd_addr   = (r_state == ST_IDLE) ? w_in_addr : w_scan_addr;

    wnhs_table #(
        .DEPTH       (DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_in_addr),
        .i_wr_data (WEIGHT_BITS'(i_link_weight)),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // threshold is floor(sum * r / 2^RAND_BITS)
    assign w_thr      = r_acc[ACC_W-1 -: SUM_W];
    assign w_run_next = r_run + SUM_W'(w_rd_data);

    // result goes to the output register once it is empty or being taken
    assign w_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_dst    = r_dst;
        n_row_ok = r_row_ok;
        n_dst_ok = r_dst_ok;
        n_rand   = r_rand;
        n_col    = r_col;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_run    = r_run;
        n_hop    = r_hop;
        n_hit    = r_hit;
        n_rv     = w_issue;
        n_pv     = r_rv && (r_state == ST_SUM);
        n_rcol   = w_issue ? r_col[IDX_W-1:0] : r_rcol;

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept && (i_cmd == wnhs_pkg::CMD_QUERY)) begin
                    n_cur    = w_in_row;
                    n_dst    = w_in_dst;
                    n_row_ok = w_in_row_ok;
                    n_dst_ok = w_in_dst_ok;
                    n_rand   = RAND_BITS'(i_rand_fraction);
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // fallback node 0 unless something better turns up
                n_hop = '0;
                n_hit = 1'b0;
                if (r_row_ok && r_dst_ok && (w_rd_data != '0)) begin
                    n_hop   = r_dst;
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (!r_row_ok) begin
                    n_state = ST_DONE;
                end else begin
                    n_col   = '0;
                    n_acc   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                // read, multiply, accumulate: one entry per cycle, three deep
                if (w_issue) begin
                    n_col = r_col + 1'b1;
                end
                if (r_rv) begin
                    n_prod = PROD_W'(w_rd_data) * PROD_W'(r_rand);
                end
                if (r_pv) begin
                    n_acc = r_acc + ACC_W'(r_prod);
                end
                if (!w_issue && !r_rv && !r_pv) begin
                    n_col   = '0;
                    n_run   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_col = r_col + 1'b1;
                end
                if (r_rv) begin
                    n_run = w_run_next;
                end
                if (r_rv && (w_thr < w_run_next)) begin
                    n_hop   = r_rcol;
                    n_state = ST_DONE;
                end else if (!w_issue && !r_rv) begin
                    // empty row: keep node 0
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_hop   = r_out_hop;
        n_out_hit   = r_out_hit;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_hop   = NODE_W'(r_hop);
            n_out_hit   = r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_rv        <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_rv        <= n_rv;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_dst     <= n_dst;
        r_row_ok  <= n_row_ok;
        r_dst_ok  <= n_dst_ok;
        r_rand    <= n_rand;
        r_rcol    <= n_rcol;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_run     <= n_run;
        r_hop     <= n_hop;
        r_hit     <= n_hit;
        r_out_hop <= n_out_hop;
        r_out_hit <= n_out_hit;
    end

    assign o_out_valid  = r_out_valid;
    assign o_next_hop   = r_out_hop;
    assign o_direct_hit = r_out_hit;

    // a finished query lands in the output register and frees the input
    `WNHS_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, w_load, o_out_valid && (r_state == ST_IDLE), "result not loaded after query end")
    // a scan that runs off the row end only happens on an all-zero row
    `WNHS_ASSERT_SAME(a_scan_exhausted, i_clk, i_rst_n, (r_state == ST_SCAN) && !w_issue && !r_rv, r_run == '0, "scan missed a neighbour in a nonzero row")
    // column counter never passes the row length
    `WNHS_ASSERT_SAME(a_col_bound, i_clk, i_rst_n, (r_state == ST_SUM) || (r_state == ST_SCAN), r_col <= CNT_W'(ACT), "column counter out of range")

endmodule

`default_nettype wire
